FILE: hw/rtl/rgb_laplacian_sharpen_3x3_defines.svh
// assertion macros for the sharpen filter checker
// no dependencies; included by the checker file only
`ifndef RGB_LAPLACIAN_SHARPEN_3X3_DEFINES_SVH
`define RGB_LAPLACIAN_SHARPEN_3X3_DEFINES_SVH

// property checked at every edge, reset included
`define RLS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// property checked outside reset
`define RLS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

FILE: hw/rtl/rls_pkg.sv
// shared constants and types of the rgb sharpen filter
// no dependencies; imported by every module of the block except the generic line store
`default_nettype none

package rls_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int PIXEL_BITS = 16;
   localparam int CHANNELS   = 3;

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int WID_BITS = COL_BITS + 1;
   localparam int ROW_BITS = 16;
   localparam int FW_BITS  = 13;

   localparam int CHAN_BITS         = 16;
   localparam int COLUMN_FIELD_BITS = 12;
   localparam int REQ_DATA_BITS     = 48;
   localparam int RSP_FIELD_BITS    = CHANNELS * CHAN_BITS + COLUMN_FIELD_BITS + ROW_BITS;
   localparam int RSP_DATA_BITS     = 80;
   localparam int RSP_PAD_BITS      = RSP_DATA_BITS - RSP_FIELD_BITS;

   localparam int SUM_BITS = (PIXEL_BITS + 4 > CHAN_BITS + 1) ? PIXEL_BITS + 4 : CHAN_BITS + 1;
   localparam int PIX_WORD = CHANNELS * PIXEL_BITS;

   localparam int WIN_TAPS     = 3;
   localparam int WIN_IDX_BITS = $clog2(WIN_TAPS);

   localparam int RESET_WIDTH     = 640;
   localparam int RESET_WIDTH_EFF = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
   localparam int RESET_HEIGHT    = 480;
   localparam int RESET_CLAMP_MAX = 65535;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLAMP_MAX    = 2'd2;

   typedef logic [CHANNELS-1:0][PIXEL_BITS-1:0] pix_type;

   // one pixel handed from the line store stage to the window stage
   typedef struct packed {
      logic                pass;
      logic                first;
      logic                has_out;
      logic                xlast;
      logic                ylast;
      logic [COL_BITS-1:0] col;
      logic [ROW_BITS-1:0] row;
      pix_type             p;
      pix_type             m;
      pix_type             a;
   } load_type;

endpackage

`default_nettype wire

FILE: hw/rtl/rls_line_ram.sv
// single line store: one write port, one registered read port
// generic, no package dependency
`default_nettype none

module rls_line_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 48,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/rls_lane.sv
// one colour lane: 5-point sharpen of a channel and clamp to 0..clamp_max
// depends on rls_pkg
`default_nettype none

module rls_lane import rls_pkg::*; (
   input  wire logic [PIXEL_BITS-1:0] ctr,
   input  wire logic [PIXEL_BITS-1:0] top,
   input  wire logic [PIXEL_BITS-1:0] bot,
   input  wire logic [PIXEL_BITS-1:0] lft,
   input  wire logic [PIXEL_BITS-1:0] rgt,
   input  wire logic [CHAN_BITS-1:0]  clamp_max,
   output logic      [CHAN_BITS-1:0]  result
);

   logic [SUM_BITS-1:0] ctr_x;
   logic [SUM_BITS-1:0] sum;

   assign ctr_x = SUM_BITS'(ctr);
   assign sum   = (ctr_x << 2) + ctr_x - SUM_BITS'(top) - SUM_BITS'(bot)
                - SUM_BITS'(lft) - SUM_BITS'(rgt);

   always_comb begin
      if (sum[SUM_BITS-1]) begin
         result = '0;
      end else if (sum > SUM_BITS'(clamp_max)) begin
         result = clamp_max;
      end else begin
         result = CHAN_BITS'(sum);
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/rls_emit.sv
// window registers, result sequencer, colour lanes and result register
// depends on rls_pkg and rls_lane
`default_nettype none

module rls_emit import rls_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     load_valid,
   input  wire load_type                 load,
   input  wire logic [CHAN_BITS-1:0]     clamp_max,
   output logic                          s2_free,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,
   output logic                          rsp_tlast
);

   typedef struct packed {
      logic                pass;
      logic                xlast;
      logic                ylast;
      logic [COL_BITS-1:0] col;
      logic [ROW_BITS-1:0] row;
      pix_type             p;
   } s2_type;

   pix_type above_ff [WIN_TAPS];
   pix_type above_in [WIN_TAPS];
   pix_type mid_ff   [WIN_TAPS];
   pix_type mid_in   [WIN_TAPS];
   pix_type new_ff   [WIN_TAPS];
   pix_type new_in   [WIN_TAPS];

   logic   s2_valid_ff, s2_valid_in;
   s2_type s2_ff, s2_in;
   logic   kx_ff, kx_in;
   logic   ky_ff, ky_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                     rsp_last_ff;

   logic [WIN_IDX_BITS-1:0] ci, li;
   pix_type                 ctr, top, bot, lft, rgt;
   logic [CHANNELS-1:0][CHAN_BITS-1:0] lane_out, out_chan;
   logic [COL_BITS-1:0]     out_col;
   logic [ROW_BITS-1:0]     out_row;
   logic                    next_exists, last, out_load;

   // window shift, refilled at the start of every line
   always_comb begin
      above_in = above_ff;
      mid_in   = mid_ff;
      new_in   = new_ff;
      if (load_valid && !load.pass) begin
         if (load.first) begin
            for (int i = 0; i < WIN_TAPS; i++) begin
               above_in[i] = load.a;
               mid_in[i]   = load.m;
               new_in[i]   = load.p;
            end
         end else begin
            for (int i = 0; i < WIN_TAPS - 1; i++) begin
               above_in[i] = above_ff[i+1];
               mid_in[i]   = mid_ff[i+1];
               new_in[i]   = new_ff[i+1];
            end
            above_in[WIN_TAPS-1] = load.a;
            mid_in[WIN_TAPS-1]   = load.m;
            new_in[WIN_TAPS-1]   = load.p;
         end
      end
   end

   always_ff @(posedge clock) begin
      above_ff <= above_in;
      mid_ff   <= mid_in;
      new_ff   <= new_in;
   end

   // tap selection: right edge repeats the newest column, bottom edge the newest row
   always_comb begin
      ci = kx_ff ? WIN_IDX_BITS'(2) : WIN_IDX_BITS'(1);
      li = kx_ff ? WIN_IDX_BITS'(1) : WIN_IDX_BITS'(0);
      if (!ky_ff) begin
         ctr = mid_ff[ci];
         top = above_ff[ci];
         bot = new_ff[ci];
         lft = mid_ff[li];
         rgt = mid_ff[WIN_TAPS-1];
      end else begin
         ctr = new_ff[ci];
         top = mid_ff[ci];
         bot = new_ff[ci];
         lft = new_ff[li];
         rgt = new_ff[WIN_TAPS-1];
      end
   end

   for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
      rls_lane u_lane (
         .ctr       (ctr[g]),
         .top       (top[g]),
         .bot       (bot[g]),
         .lft       (lft[g]),
         .rgt       (rgt[g]),
         .clamp_max (clamp_max),
         .result    (lane_out[g])
      );
   end

   assign next_exists = (!kx_ff && s2_ff.xlast) || (!ky_ff && s2_ff.ylast);
   assign last        = s2_ff.pass || !next_exists;
   assign out_load    = s2_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign s2_free     = !s2_valid_ff || (out_load && last);

   // merge lanes and position into one result beat
   always_comb begin
      for (int g = 0; g < CHANNELS; g++) begin
         out_chan[g] = s2_ff.pass ? CHAN_BITS'(s2_ff.p[g]) : lane_out[g];
      end
      out_col = (s2_ff.pass || kx_ff) ? s2_ff.col : s2_ff.col - COL_BITS'(1);
      out_row = (s2_ff.pass || ky_ff) ? s2_ff.row : s2_ff.row - ROW_BITS'(1);
      rsp_data_in = {RSP_PAD_BITS'(0), out_row, COLUMN_FIELD_BITS'(out_col), out_chan};
   end

   // result order: upper row first, left column first
   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_in       = s2_ff;
      kx_in       = kx_ff;
      ky_in       = ky_ff;
      if (load_valid) begin
         s2_valid_in = load.pass || load.has_out;
         s2_in.pass  = load.pass;
         s2_in.xlast = load.xlast;
         s2_in.ylast = load.ylast;
         s2_in.col   = load.col;
         s2_in.row   = load.row;
         s2_in.p     = load.p;
         kx_in       = 1'b0;
         ky_in       = 1'b0;
      end else if (out_load) begin
         if (last) begin
            s2_valid_in = 1'b0;
         end else if (!kx_ff && s2_ff.xlast) begin
            kx_in = 1'b1;
         end else begin
            kx_in = 1'b0;
            ky_in = 1'b1;
         end
      end
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_ff <= s2_in;
      kx_ff <= kx_in;
      ky_ff <= ky_in;
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/rgb_laplacian_sharpen_3x3.sv
// Streaming 5-point sharpen of RGB pixels, three colour lanes side by side.
// A pixel passes the input stage, the window stage and the result register in that order.
// Throughput: 1 pixel per cycle while results are taken; a pixel causing n results
// (2 at a line end or in the last row, 4 for the last pixel) holds the input until all n are taken.
// Reset (synchronous): empties the pipeline, clears the position counters and loads
// width 640, height 480, max 65535; line stores are not cleared. Depends on rls_pkg.
`default_nettype none

module rgb_laplacian_sharpen_3x3 import rls_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // pixel_red, pixel_green, pixel_blue
   input  wire logic [REQ_DATA_BITS-1:0]  req_tdata,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // out_red, out_green, out_blue, out_column, out_row, zero pad
   output logic      [RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                           rsp_tlast,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data
);

   typedef struct packed {
      logic                pass;
      logic                first;
      logic                xlast;
      logic                ylast;
      logic                r_ge1;
      logic                r_ge2;
      logic [COL_BITS-1:0] col;
      logic [ROW_BITS-1:0] row;
      pix_type             p;
   } s1_type;

   logic [WID_BITS-1:0]  w_eff_ff, w_eff_in, w_new;
   logic [ROW_BITS-1:0]  h_eff_ff, h_eff_in, h_new;
   logic [CHAN_BITS-1:0] max_ff, max_in;
   logic [FW_BITS-1:0]   fw_raw;

   logic [COL_BITS-1:0] c_ff, c_in, w_last;
   logic [ROW_BITS-1:0] r_ff, r_in, h_last;
   logic                bypass, cfg_geom, accept;

   logic    s1_valid_ff, s1_valid_in;
   s1_type  s1_ff, s1_in;
   logic    s1_move, s2_free, ram_wr;
   pix_type p_in, mid_rd, above_rd, m_val, a_val;
   load_type load;

   assign csr_ready = 1'b1;
   assign fw_raw    = csr_data[FW_BITS-1:0];
   assign cfg_geom  = csr_valid &&
                      (csr_index == CSR_FRAME_WIDTH || csr_index == CSR_FRAME_HEIGHT);

   // width or height zero counts as one, width above the line store is cut to it
   always_comb begin
      if (fw_raw == '0) begin
         w_new = WID_BITS'(1);
      end else if (int'(fw_raw) > MAX_WIDTH) begin
         w_new = WID_BITS'(MAX_WIDTH);
      end else begin
         w_new = WID_BITS'(fw_raw);
      end
      h_new = (csr_data == '0) ? ROW_BITS'(1) : csr_data;
   end

   always_comb begin
      w_eff_in = w_eff_ff;
      h_eff_in = h_eff_ff;
      max_in   = max_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  w_eff_in = w_new;
            CSR_FRAME_HEIGHT: h_eff_in = h_new;
            CSR_CLAMP_MAX:    max_in   = csr_data;
            default: begin
            end
         endcase
      end
   end

   assign w_last = COL_BITS'(w_eff_ff - WID_BITS'(1));
   assign h_last = h_eff_ff - ROW_BITS'(1);
   assign bypass = (w_eff_ff < WID_BITS'(3)) || (h_eff_ff < ROW_BITS'(3));

   assign s1_move    = s1_valid_ff && s2_free;
   assign req_tready = !s1_valid_ff || s1_move;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      c_in = c_ff;
      r_in = r_ff;
      if (cfg_geom) begin
         c_in = '0;
         r_in = '0;
      end else if (accept) begin
         if (c_ff == w_last) begin
            c_in = '0;
            r_in = (r_ff == h_last) ? '0 : r_ff + ROW_BITS'(1);
         end else begin
            c_in = c_ff + COL_BITS'(1);
         end
      end
   end

   always_comb begin
      for (int g = 0; g < CHANNELS; g++) begin
         p_in[g] = req_tdata[g*CHAN_BITS +: PIXEL_BITS];
      end
      s1_in.pass  = bypass;
      s1_in.first = (c_ff == '0);
      s1_in.xlast = (c_ff == w_last);
      s1_in.ylast = (r_ff == h_last);
      s1_in.r_ge1 = (r_ff >= ROW_BITS'(1));
      s1_in.r_ge2 = (r_ff >= ROW_BITS'(2));
      s1_in.col   = c_ff;
      s1_in.row   = r_ff;
      s1_in.p     = p_in;
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_eff_ff    <= WID_BITS'(RESET_WIDTH_EFF);
         h_eff_ff    <= ROW_BITS'(RESET_HEIGHT);
         max_ff      <= CHAN_BITS'(RESET_CLAMP_MAX);
         c_ff        <= '0;
         r_ff        <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         w_eff_ff    <= w_eff_in;
         h_eff_ff    <= h_eff_in;
         max_ff      <= max_in;
         c_ff        <= c_in;
         r_ff        <= r_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // lines above the top of the frame repeat its nearest row
   assign m_val  = s1_ff.r_ge1 ? mid_rd : s1_ff.p;
   assign a_val  = s1_ff.r_ge2 ? above_rd : m_val;
   assign ram_wr = s1_move && !s1_ff.pass;

   rls_line_ram #(
      .DEPTH (MAX_WIDTH),
      .WIDTH (PIX_WORD)
   ) u_line_middle (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (s1_ff.col),
      .wr_data (s1_ff.p),
      .rd_en   (accept),
      .rd_addr (c_ff),
      .rd_data (mid_rd)
   );

   rls_line_ram #(
      .DEPTH (MAX_WIDTH),
      .WIDTH (PIX_WORD)
   ) u_line_above (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (s1_ff.col),
      .wr_data (m_val),
      .rd_en   (accept),
      .rd_addr (c_ff),
      .rd_data (above_rd)
   );

   always_comb begin
      load.pass    = s1_ff.pass;
      load.first   = s1_ff.first;
      load.has_out = !s1_ff.first && s1_ff.r_ge1;
      load.xlast   = s1_ff.xlast;
      load.ylast   = s1_ff.ylast;
      load.col     = s1_ff.col;
      load.row     = s1_ff.row;
      load.p       = s1_ff.p;
      load.m       = m_val;
      load.a       = a_val;
   end

   rls_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load_valid (s1_move),
      .load       (load),
      .clamp_max  (max_ff),
      .s2_free    (s2_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/rls_checker.sv
// port-level checks of the sharpen filter, bound to the top level
// depends on rls_pkg and the assertion macro header
`default_nettype none
`include "rgb_laplacian_sharpen_3x3_defines.svh"

module rls_checker import rls_pkg::*; (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      rsp_tvalid,
   input wire logic                      rsp_tready,
   input wire logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   input wire logic                      rsp_tlast,
   input wire logic                      csr_valid,
   input wire logic                      csr_ready
);

   `RLS_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_tvalid, "result beat valid after reset")
   `RLS_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result beat changed")
   `RLS_ASSERT(a_csr_ready, clock, reset, csr_valid |-> csr_ready, "configuration write stalled")

endmodule

bind rgb_laplacian_sharpen_3x3 rls_checker u_rls_checker (.*);

`default_nettype wire

FILE: tb/tb.sv
// testbench of the rgb 5-point sharpen filter: streams raster pixels and register writes,
// predicts every sharpened pixel on its own and checks the result stream beat by beat
// depends on rls_pkg and rgb_laplacian_sharpen_3x3
module tb import rls_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 10;
   localparam int LONG_STALL    = 300;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_LIMIT  = 40;

   typedef struct {
      pix_type                      colour;
      logic [COLUMN_FIELD_BITS-1:0] column;
      logic [ROW_BITS-1:0]          row;
      logic                         last;
   } result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      rsp_tlast;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   pix_type        pending_pixels [$];
   result_type     due_results [$];
   int             req_idle_pct = 0;
   int             rsp_idle_pct = 0;
   int             failures = 0;
   int             cycle_count = 0;
   logic           stall_request = 1'b0;
   logic           stall_taken = 1'b0;
   int             stall_left = 0;
   string          field_name [6] = '{"red", "green", "blue", "column", "row", "last"};

   // filter state as the block should hold it
   pix_type above_line [MAX_WIDTH];
   pix_type middle_line [MAX_WIDTH];
   pix_type mid_taps [3];
   pix_type new_taps [3];
   int      col_pos = 0;
   int      row_pos = 0;
   int      width_reg = RESET_WIDTH;
   int      height_reg = RESET_HEIGHT;
   int      max_reg = RESET_CLAMP_MAX;

   rgb_laplacian_sharpen_3x3 uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [CHAN_BITS-1:0] clamp_channel(input int centre, input int up,
         input int down, input int left, input int right);
      int v;
      v = 5 * centre - up - down - left - right;
      if (v < 0) return '0;
      if (v > max_reg) return max_reg[CHAN_BITS-1:0];
      return v[CHAN_BITS-1:0];
   endfunction

   function automatic void apply_register(input logic [CSR_INDEX_BITS-1:0] index,
         input logic [CSR_DATA_BITS-1:0] value);
      case (index)
         CSR_FRAME_WIDTH: begin
            width_reg = int'(value[FW_BITS-1:0]);
            col_pos = 0;
            row_pos = 0;
         end
         CSR_FRAME_HEIGHT: begin
            height_reg = int'(value);
            col_pos = 0;
            row_pos = 0;
         end
         CSR_CLAMP_MAX: begin
            max_reg = int'(value);
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void predict_sharpen(input pix_type p);
      int w, h, c, r, nx, ny, total, n, li, ci, x;
      int xs [2];
      int ys [2];
      pix_type m, top, bot, v;
      pix_type row_taps [3];
      result_type e;
      w = (width_reg == 0) ? 1 : width_reg;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = (height_reg == 0) ? 1 : height_reg;
      if (col_pos >= w) col_pos = 0;
      if (row_pos >= h) row_pos = 0;
      c = col_pos;
      r = row_pos;
      if (w < 3 || h < 3) begin
         e.colour = p;
         e.column = c[COLUMN_FIELD_BITS-1:0];
         e.row = r[ROW_BITS-1:0];
         e.last = 1'b1;
         due_results.push_back(e);
      end else begin
         m = (r >= 1) ? middle_line[c] : p;
         if (c == 0) begin
            for (int k = 0; k < 3; k++) begin
               new_taps[k] = p;
               mid_taps[k] = m;
            end
         end else begin
            new_taps[0] = new_taps[1];
            new_taps[1] = new_taps[2];
            new_taps[2] = p;
            mid_taps[0] = mid_taps[1];
            mid_taps[1] = mid_taps[2];
            mid_taps[2] = m;
         end
         nx = 0;
         ny = 0;
         if (c >= 1) begin
            xs[nx] = c - 1;
            nx++;
            if (c == w - 1) begin
               xs[nx] = c;
               nx++;
            end
         end
         if (r >= 1) begin
            ys[ny] = r - 1;
            ny++;
            if (r == h - 1) begin
               ys[ny] = r;
               ny++;
            end
         end
         total = nx * ny;
         n = 0;
         for (int i = 0; i < ny; i++) begin
            for (int k = 0; k < nx; k++) begin
               li = (xs[k] == c) ? 1 : 0;
               ci = li + 1;
               if (ys[i] == r - 1) begin
                  row_taps = mid_taps;
                  top = (r >= 2) ? above_line[xs[k]] : mid_taps[ci];
               end else begin
                  row_taps = new_taps;
                  top = mid_taps[ci];
               end
               bot = new_taps[ci];
               for (int j = 0; j < CHANNELS; j++) begin
                  v[j] = clamp_channel(row_taps[ci][j], top[j], bot[j], row_taps[li][j],
                                       row_taps[2][j]);
               end
               e.colour = v;
               e.column = xs[k][COLUMN_FIELD_BITS-1:0];
               e.row = ys[i][ROW_BITS-1:0];
               e.last = (n == total - 1);
               due_results.push_back(e);
               n++;
            end
         end
         for (int k = 0; k < nx; k++) begin
            x = xs[k];
            ci = (xs[k] == c) ? 2 : 1;
            if (r >= 1) above_line[x] = mid_taps[ci];
            middle_line[x] = new_taps[ci];
         end
      end
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   function automatic pix_type random_pixel(input pix_type base);
      pix_type p;
      for (int j = 0; j < CHANNELS; j++) begin
         if ($urandom_range(3) == 0) p[j] = 16'($urandom);
         else p[j] = base[j] + 16'($urandom_range(64)) - 16'd32;
      end
      return p;
   endfunction

   // pixel driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_sharpen(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
               req_tdata <= pending_pixels.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
      end else if (stall_request && !stall_taken) begin
         stall_taken <= 1'b1;
         stall_left <= LONG_STALL;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end
   end

   // result monitor and receiver back-pressure
   always @(posedge clock) begin
      result_type want;
      logic [15:0] want_f [6];
      logic [15:0] got_f [6];
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("%0t unexpected result beat: expected none, got %h last %b",
                           $time, rsp_tdata, rsp_tlast);
            end else begin
               want = due_results.pop_front();
               want_f = '{want.colour[0], want.colour[1], want.colour[2],
                          16'(want.column), want.row, 16'(want.last)};
               got_f = '{rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32],
                         16'(rsp_tdata[59:48]), rsp_tdata[75:60], 16'(rsp_tlast)};
               for (int f = 0; f < 6; f++) begin
                  if (got_f[f] !== want_f[f]) begin
                     failures++;
                     if (failures <= REPORT_LIMIT)
                        $display("%0t %s of (%0d,%0d): expected %h, got %h", $time,
                                 field_name[f], want.column, want.row, want_f[f], got_f[f]);
                  end
               end
            end
         end
         if ((stall_request && !stall_taken) || stall_left > 0) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
         input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      apply_register(index, value);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_pixels.size() != 0 || req_tvalid || due_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic push_frame(input int count, input pix_type base);
      for (int i = 0; i < count; i++) pending_pixels.push_back(random_pixel(base));
   endtask

   task automatic random_frames(input int budget);
      int sent, w, h, count;
      pix_type base;
      sent = 0;
      while (sent < budget) begin
         case ($urandom_range(9))
            0: begin
               w = $urandom_range(1, 2);
               h = $urandom_range(1, 5);
            end
            1: begin
               w = $urandom_range(1, 6);
               h = $urandom_range(1, 2);
            end
            default: begin
               w = $urandom_range(3, 8);
               h = $urandom_range(3, 6);
            end
         endcase
         write_reg(CSR_FRAME_WIDTH, 16'(w));
         write_reg(CSR_FRAME_HEIGHT, 16'(h));
         case ($urandom_range(5))
            0: write_reg(CSR_CLAMP_MAX, 16'h0000);
            1: write_reg(CSR_CLAMP_MAX, 16'hFFFF);
            2: write_reg(CSR_CLAMP_MAX, 16'($urandom));
            default: begin
            end
         endcase
         count = w * h * (($urandom_range(3) == 0) ? 2 : 1);
         if ($urandom_range(4) == 0) count = $urandom_range(1, count);
         base = pix_type'({$urandom, $urandom});
         push_frame(count, base);
         wait_drained();
         sent += count;
      end
   endtask

   initial begin
      logic [15:0] levels [3];
      pix_type p;
      levels = '{16'hFFFF, 16'h0000, 16'h5A5A};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: smallest filtered frame with extreme levels, then clamp to zero
      req_idle_pct = 28;
      rsp_idle_pct = 75;
      write_reg(CSR_CLAMP_MAX, 16'hFFFF);
      write_reg(CSR_FRAME_WIDTH, 16'd3);
      write_reg(CSR_FRAME_HEIGHT, 16'd3);
      for (int i = 0; i < 9; i++) begin
         for (int j = 0; j < CHANNELS; j++) p[j] = levels[(i + j) % 3];
         pending_pixels.push_back(p);
      end
      wait_drained();
      write_reg(CSR_CLAMP_MAX, 16'h0000);
      push_frame(9, '0);
      wait_drained();

      // small frames pass through unclamped
      write_reg(CSR_CLAMP_MAX, 16'd100);
      write_reg(CSR_FRAME_WIDTH, 16'd2);
      write_reg(CSR_FRAME_HEIGHT, 16'd2);
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < CHANNELS; j++) p[j] = (i + j) % 2 ? 16'h8001 : 16'hFFFF;
         pending_pixels.push_back(p);
      end
      wait_drained();
      write_reg(CSR_FRAME_WIDTH, 16'd0);
      push_frame(2, '1);
      wait_drained();
      write_reg(CSR_UNUSED, 16'hFFFF);
      write_reg(CSR_FRAME_WIDTH, 16'hFFFF);
      write_reg(CSR_FRAME_HEIGHT, 16'd0);
      push_frame(3, '0);
      wait_drained();

      // tallest frame, first two lines only
      write_reg(CSR_CLAMP_MAX, 16'hFFFF);
      write_reg(CSR_FRAME_WIDTH, 16'd3);
      write_reg(CSR_FRAME_HEIGHT, 16'hFFFF);
      push_frame(6, pix_type'({16'h8000, 16'h4000, 16'hC000}));
      wait_drained();

      random_frames(15);
      req_idle_pct = 75;
      rsp_idle_pct = 28;
      random_frames(15);
      req_idle_pct = 0;
      rsp_idle_pct = 0;

      // long receiver hold-off while pixels keep coming
      write_reg(CSR_FRAME_WIDTH, 16'd8);
      write_reg(CSR_FRAME_HEIGHT, 16'd3);
      write_reg(CSR_CLAMP_MAX, 16'd40000);
      push_frame(24, pix_type'({$urandom, $urandom}));
      stall_request = 1'b1;
      wait_drained();
      random_frames(10);

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
